// ----- design/quicksort_three_way_defines.svh -----
// ----------------------------------------------------------------------------
// quicksort_three_way_defines.svh
// Assertion macros used by the checker file of the sort block.
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_THREE_WAY_DEFINES_SVH
`define QUICKSORT_THREE_WAY_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define QS3W_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define QS3W_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/qs3w_pkg.sv -----
// ----------------------------------------------------------------------------
// qs3w_pkg
// Sizes, word types, request structs and sequencer states of the sort block.
// ----------------------------------------------------------------------------
`default_nettype none

package qs3w_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [CNT_W-1:0]              cnt_t;

    typedef struct packed {
        value_t value;
        logic   is_last_in;
    } in_item_t;

    typedef struct packed {
        value_t sorted_value;
        logic   is_last_out;
        logic   overflow;
    } out_item_t;

    typedef struct packed {
        idx_t lo;
        idx_t hi;
    } range_t;

    typedef struct packed {
        logic   wr_en;
        idx_t   wr_addr;
        value_t wr_data;
        logic   rd_en;
        idx_t   rd_addr;
    } store_req_t;

    typedef struct packed {
        logic   push;
        range_t push_range;
        logic   pop;
    } stack_req_t;

    typedef struct packed {
        logic   empty;
        range_t top_range;
    } stack_stat_t;

    typedef struct packed {
        logic less;
        logic greater;
    } cmp_res_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_POP,
        S_POP_WAIT,
        S_PIV,
        S_RDI,
        S_CMP,
        S_WR_I,
        S_GT,
        S_GT2,
        S_PUSH_HI,
        S_PUSH_LO,
        S_EMIT,
        S_EMIT_W
    } state_t;

endpackage

`default_nettype wire

// ----- design/quicksort_three_way.sv -----
// Loading: one word per cycle while s_ready is high; a word beyond 64 is dropped.
// Sort: start pushes the whole set; each popped range has its pivot read, then every
// word is read and compared, a smaller one swapped to lt and a greater one to gt, and
// the two outer parts pushed, all through one memory port; an empty stack ends the sort.
// Emit: each result is read, then registered; next set is taken once the last is loaded.
// Reset (aresetn low, synchronous) empties the store, clears overflow and drops any output.
// ----------------------------------------------------------------------------
// quicksort_three_way
// Three-way partition quicksort over a 64-word store with an explicit range stack.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_three_way (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  qs3w_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output qs3w_pkg::out_item_t  m_data
);
    import qs3w_pkg::*;

    store_req_t  store_req;
    value_t      store_rd;
    stack_req_t  stack_req;
    stack_stat_t stack_stat;
    cmp_res_t    cmp_res;
    value_t      pivot;

    qs3w_store u_store (
        .aclk      (aclk),
        .req_i     (store_req),
        .rd_data_o (store_rd)
    );

    qs3w_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (stack_req),
        .stat_o  (stack_stat)
    );

    qs3w_cmp u_cmp (
        .a_i   (store_rd),
        .b_i   (pivot),
        .res_o (cmp_res)
    );

    qs3w_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .store_req_o  (store_req),
        .store_rd_i   (store_rd),
        .stack_req_o  (stack_req),
        .stack_stat_i (stack_stat),
        .cmp_i        (cmp_res),
        .pivot_o      (pivot)
    );

endmodule

`default_nettype wire

// ----- design/qs3w_store.sv -----
// ----------------------------------------------------------------------------
// qs3w_store
// Element memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qs3w_store (
    input  wire                   aclk,
    input  qs3w_pkg::store_req_t  req_i,
    output qs3w_pkg::value_t      rd_data_o
);
    import qs3w_pkg::*;

    value_t mem [CAPACITY];
    value_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req_i.wr_en) begin
            mem[req_i.wr_addr] <= req_i.wr_data;
        end
        // hold the last word read until the next read
        if (req_i.rd_en) begin
            rd_data_reg <= mem[req_i.rd_addr];
        end
    end

    assign rd_data_o = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/qs3w_stack.sv -----
// ----------------------------------------------------------------------------
// qs3w_stack
// Pending-range stack held in a small memory, with a registered pop read.
// ----------------------------------------------------------------------------
`default_nettype none

module qs3w_stack (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  qs3w_pkg::stack_req_t  req_i,
    output qs3w_pkg::stack_stat_t stat_o
);
    import qs3w_pkg::*;

    range_t mem [CAPACITY];
    range_t top_reg;
    cnt_t   sp_reg;
    cnt_t   sp_next;
    cnt_t   sp_dec;
    logic   full;

    assign sp_dec = sp_reg - CNT_W'(1);
    assign full   = (sp_reg == CNT_W'(CAPACITY));

    always_comb begin
        sp_next = sp_reg;
        priority if (req_i.push && !full) begin
            sp_next = sp_reg + CNT_W'(1);
        end else if (req_i.pop && sp_reg != '0) begin
            sp_next = sp_dec;
        end else begin
            sp_next = sp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_i.push && !full) begin
            mem[sp_reg[IDX_W-1:0]] <= req_i.push_range;
        end
        if (req_i.pop) begin
            top_reg <= mem[sp_dec[IDX_W-1:0]];
        end
    end

    assign stat_o.empty     = (sp_reg == '0);
    assign stat_o.top_range = top_reg;

endmodule

`default_nettype wire

// ----- design/qs3w_cmp.sv -----
// ----------------------------------------------------------------------------
// qs3w_cmp
// Shared signed comparator: element word against the pivot.
// ----------------------------------------------------------------------------
`default_nettype none

module qs3w_cmp (
    input  qs3w_pkg::value_t   a_i,
    input  qs3w_pkg::value_t   b_i,
    output qs3w_pkg::cmp_res_t res_o
);
    import qs3w_pkg::*;

    assign res_o.less    = (a_i < b_i);
    assign res_o.greater = (a_i > b_i);

endmodule

`default_nettype wire

// ----- design/qs3w_seq.sv -----
// ----------------------------------------------------------------------------
// qs3w_seq
// Sequencer: loads words, runs the three-way partition passes, emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module qs3w_seq (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  qs3w_pkg::in_item_t     s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output qs3w_pkg::out_item_t    m_data,
    output qs3w_pkg::store_req_t   store_req_o,
    input  qs3w_pkg::value_t       store_rd_i,
    output qs3w_pkg::stack_req_t   stack_req_o,
    input  qs3w_pkg::stack_stat_t  stack_stat_i,
    input  qs3w_pkg::cmp_res_t     cmp_i,
    output qs3w_pkg::value_t       pivot_o
);
    import qs3w_pkg::*;

    state_t    state_reg, state_next;
    cnt_t      count_reg, count_next;
    logic      ovf_reg, ovf_next;
    idx_t      lo_reg, lo_next;
    idx_t      hi_reg, hi_next;
    cnt_t      lt_reg, lt_next;
    cnt_t      i_reg, i_next;
    cnt_t      gt_end_reg, gt_end_next;
    value_t    pv_reg, pv_next;
    value_t    kv_reg, kv_next;
    cnt_t      emit_idx_reg, emit_idx_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic out_free;
    logic emit_last;
    logic scan_on;
    cnt_t gt_dec;
    cnt_t lt_dec;
    cnt_t count_dec;

    assign out_free  = !m_valid_reg || m_ready;
    assign count_dec = count_reg - CNT_W'(1);
    assign emit_last = (emit_idx_reg == count_dec);
    assign scan_on   = (i_reg < gt_end_reg);
    assign gt_dec    = gt_end_reg - CNT_W'(1);
    assign lt_dec    = lt_reg - CNT_W'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid && s_data.is_last_in) begin
                    state_next = S_START;
                end
            end
            S_START:    state_next = S_POP;
            S_POP:      state_next = stack_stat_i.empty ? S_EMIT : S_POP_WAIT;
            S_POP_WAIT: state_next = S_PIV;
            S_PIV:      state_next = S_RDI;
            S_RDI:      state_next = scan_on ? S_CMP : S_PUSH_HI;
            S_CMP: begin
                priority if (cmp_i.less) begin
                    state_next = (lt_reg == i_reg) ? S_RDI : S_WR_I;
                end else if (cmp_i.greater) begin
                    state_next = S_GT;
                end else begin
                    state_next = S_RDI;
                end
            end
            S_WR_I:     state_next = S_RDI;
            S_GT:       state_next = S_GT2;
            S_GT2:      state_next = S_RDI;
            S_PUSH_HI:  state_next = S_PUSH_LO;
            S_PUSH_LO:  state_next = S_POP;
            S_EMIT:     state_next = S_EMIT_W;
            S_EMIT_W: begin
                if (out_free) begin
                    state_next = emit_last ? S_LOAD : S_EMIT;
                end
            end
            default:    state_next = S_LOAD;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready       = 1'b0;
        store_req_o   = '0;
        stack_req_o   = '0;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        lt_next       = lt_reg;
        i_next        = i_reg;
        gt_end_next   = gt_end_reg;
        pv_next       = pv_reg;
        kv_next       = kv_reg;
        emit_idx_next = emit_idx_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        unique case (state_reg)
            S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (count_reg < CNT_W'(CAPACITY)) begin
                        store_req_o.wr_en   = 1'b1;
                        store_req_o.wr_addr = count_reg[IDX_W-1:0];
                        store_req_o.wr_data = s_data.value;
                        count_next          = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            S_START: begin
                emit_idx_next = '0;
                if (count_reg >= CNT_W'(2)) begin
                    stack_req_o.push          = 1'b1;
                    stack_req_o.push_range.lo = '0;
                    stack_req_o.push_range.hi = count_dec[IDX_W-1:0];
                end
            end
            S_POP: begin
                stack_req_o.pop = !stack_stat_i.empty;
            end
            S_POP_WAIT: begin
                lo_next             = stack_stat_i.top_range.lo;
                hi_next             = stack_stat_i.top_range.hi;
                lt_next             = {1'b0, stack_stat_i.top_range.lo};
                i_next              = {1'b0, stack_stat_i.top_range.lo};
                gt_end_next         = {1'b0, stack_stat_i.top_range.hi} + CNT_W'(1);
                store_req_o.rd_en   = 1'b1;
                store_req_o.rd_addr = stack_stat_i.top_range.hi;
            end
            S_PIV: begin
                pv_next = store_rd_i;
            end
            S_RDI: begin
                store_req_o.rd_en   = scan_on;
                store_req_o.rd_addr = i_reg[IDX_W-1:0];
            end
            S_CMP: begin
                kv_next = store_rd_i;
                priority if (cmp_i.less) begin
                    // the word at lt equals the pivot whenever lt trails i
                    store_req_o.wr_en   = 1'b1;
                    store_req_o.wr_addr = lt_reg[IDX_W-1:0];
                    store_req_o.wr_data = store_rd_i;
                    if (lt_reg == i_reg) begin
                        i_next  = i_reg + CNT_W'(1);
                        lt_next = lt_reg + CNT_W'(1);
                    end
                end else if (cmp_i.greater) begin
                    store_req_o.rd_en   = 1'b1;
                    store_req_o.rd_addr = gt_dec[IDX_W-1:0];
                end else begin
                    i_next = i_reg + CNT_W'(1);
                end
            end
            S_WR_I: begin
                store_req_o.wr_en   = 1'b1;
                store_req_o.wr_addr = i_reg[IDX_W-1:0];
                store_req_o.wr_data = pv_reg;
                i_next              = i_reg + CNT_W'(1);
                lt_next             = lt_reg + CNT_W'(1);
            end
            S_GT: begin
                store_req_o.wr_en   = 1'b1;
                store_req_o.wr_addr = i_reg[IDX_W-1:0];
                store_req_o.wr_data = store_rd_i;
            end
            S_GT2: begin
                store_req_o.wr_en   = 1'b1;
                store_req_o.wr_addr = gt_dec[IDX_W-1:0];
                store_req_o.wr_data = kv_reg;
                gt_end_next         = gt_dec;
            end
            S_PUSH_HI: begin
                if (i_reg < {1'b0, hi_reg}) begin
                    stack_req_o.push          = 1'b1;
                    stack_req_o.push_range.lo = i_reg[IDX_W-1:0];
                    stack_req_o.push_range.hi = hi_reg;
                end
            end
            S_PUSH_LO: begin
                if (lt_reg > ({1'b0, lo_reg} + CNT_W'(1))) begin
                    stack_req_o.push          = 1'b1;
                    stack_req_o.push_range.lo = lo_reg;
                    stack_req_o.push_range.hi = lt_dec[IDX_W-1:0];
                end
            end
            S_EMIT: begin
                store_req_o.rd_en   = 1'b1;
                store_req_o.rd_addr = emit_idx_reg[IDX_W-1:0];
            end
            S_EMIT_W: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.sorted_value = store_rd_i;
                    m_data_next.is_last_out  = emit_last;
                    m_data_next.overflow     = ovf_reg;
                    if (emit_last) begin
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        emit_idx_next = '0;
                    end else begin
                        emit_idx_next = emit_idx_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            emit_idx_reg <= emit_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        lt_reg     <= lt_next;
        i_reg      <= i_next;
        gt_end_reg <= gt_end_next;
        pv_reg     <= pv_next;
        kv_reg     <= kv_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pivot_o = pv_reg;

endmodule

`default_nettype wire

// ----- design/qs3w_checker.sv -----
// ----------------------------------------------------------------------------
// qs3w_checker
// Port-level checks on the sort block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quicksort_three_way_defines.svh"

module qs3w_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_valid,
    input wire                  s_ready,
    input qs3w_pkg::in_item_t   s_data,
    input wire                  m_valid,
    input wire                  m_ready,
    input qs3w_pkg::out_item_t  m_data
);
    import qs3w_pkg::*;

    // stalled result word holds
    `QS3W_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")

    // closing word of a set stops loading
    `QS3W_ASSERT_NEXT(a_last_stops_load, s_valid && s_ready && s_data.is_last_in, !s_ready, "input still ready after closing word")

    // no loading while a run is still being emitted
    `QS3W_ASSERT_SAME(a_no_load_mid_run, m_valid && !m_data.is_last_out, !s_ready, "input ready in the middle of a run")

    // overflow flag is the same on every word of a run
    `QS3W_ASSERT_SAME(a_ovf_steady, m_valid && $past(m_valid && m_ready && !m_data.is_last_out), m_data.overflow == $past(m_data.overflow), "overflow flag changed within a run")

endmodule

bind quicksort_three_way qs3w_checker u_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-way quicksort block: loads sets of words,
// predicts the sorted run of each set and checks every result word in order.
// ----------------------------------------------------------------------------
module tb;

    import qs3w_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int ITEMS        = 380;
    localparam int LONG_HOLD    = 600;
    localparam int IDLE_LIMIT   = 40000;
    localparam int TAIL_CYCLES  = 40;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_NARROW,
        STYLE_EXTREME,
        STYLE_RISING,
        STYLE_FALLING,
        STYLE_SAME
    } fill_style_t;

    typedef struct packed {
        in_item_t  word;
        logic      typed;
        out_item_t result;
    } step_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // predictor state: words held for the current set and the drop flag
    value_t    held_values [$];
    bit        dropped_any  = 1'b0;
    out_item_t sorted_due  [$];

    int        words_taken  = 0;
    int        idle_cycles  = 0;
    bit        failed       = 1'b0;
    bit        hold_off_req = 1'b0;
    bit        hold_on      = 1'b0;

    // single-word sets can be read off directly; the rest go through the predictor
    step_t directed [21] = '{
        '{'{32'sh8000_0000, 1'b1}, 1'b1, '{32'sh8000_0000, 1'b1, 1'b0}},
        '{'{32'sh7FFF_FFFF, 1'b1}, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0}},
        '{'{32'sh0000_0000, 1'b1}, 1'b1, '{32'sh0000_0000, 1'b1, 1'b0}},
        '{'{32'shFFFF_FFFF, 1'b1}, 1'b1, '{32'shFFFF_FFFF, 1'b1, 1'b0}},
        '{'{32'sh0000_0001, 1'b1}, 1'b1, '{32'sh0000_0001, 1'b1, 1'b0}},
        '{'{32'sd5,         1'b0}, 1'b0, '0},
        '{'{-32'sd3,        1'b0}, 1'b0, '0},
        '{'{32'sh7FFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{32'sd5,         1'b0}, 1'b0, '0},
        '{'{32'sh8000_0000, 1'b0}, 1'b0, '0},
        '{'{32'sd0,         1'b0}, 1'b0, '0},
        '{'{32'sd5,         1'b0}, 1'b0, '0},
        '{'{-32'sd3,        1'b1}, 1'b0, '0},
        '{'{32'sd7,         1'b0}, 1'b0, '0},
        '{'{32'sd7,         1'b0}, 1'b0, '0},
        '{'{32'sd7,         1'b0}, 1'b0, '0},
        '{'{32'sd7,         1'b1}, 1'b0, '0},
        '{'{32'sd2,         1'b0}, 1'b0, '0},
        '{'{32'sd1,         1'b1}, 1'b0, '0},
        '{'{32'sh5555_5555, 1'b0}, 1'b0, '0},
        '{'{32'shAAAA_AAAA, 1'b1}, 1'b0, '0}
    };

    quicksort_three_way DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Store a word if room; on the last, sort and (if keep) queue one result each.
    function automatic void predict_word(input in_item_t w, input bit keep);
        value_t    run [$];
        value_t    v;
        int        j;
        out_item_t r;
        if (held_values.size() < CAPACITY) begin
            held_values.push_back(w.value);
        end else begin
            dropped_any = 1'b1;
        end
        if (!w.is_last_in) begin
            return;
        end
        run = held_values;
        for (int k = 1; k < run.size(); k++) begin
            v = run[k];
            j = k - 1;
            while (j >= 0 && run[j] > v) begin
                run[j + 1] = run[j];
                j--;
            end
            run[j + 1] = v;
        end
        if (keep) begin
            foreach (run[k]) begin
                r.sorted_value = run[k];
                r.is_last_out  = (k == run.size() - 1);
                r.overflow     = dropped_any;
                sorted_due.push_back(r);
            end
        end
        held_values.delete();
        dropped_any = 1'b0;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return $urandom_range(1, 3);
        end else if (r < 9) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 8);
        end else if (r < 85) begin
            return $urandom_range(9, 24);
        end else if (r < 95) begin
            return $urandom_range(25, CAPACITY - 1);
        end
        return $urandom_range(CAPACITY, CAPACITY + 6);
    endfunction

    // Hold the word on the bus until it is taken, then update the prediction.
    task automatic offer_word(input in_item_t w, input bit typed, input out_item_t typed_res);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predict_word(w, !typed);
        if (typed) begin
            sorted_due.push_back(typed_res);
        end
        words_taken++;
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sorted_due.size() != 0) @(posedge aclk);
    endtask

    task automatic send_set(input int n, input fill_style_t style, input bit bursty);
        in_item_t w;
        value_t   base;
        int       stride;
        base   = $urandom;
        stride = $urandom_range(1, 1 << 20);
        for (int k = 0; k < n; k++) begin
            case (style)
                STYLE_RANDOM:  w.value = $urandom;
                STYLE_NARROW:  w.value = int'($urandom_range(0, 6)) - 3;
                STYLE_RISING:  w.value = k * stride - 40000000;
                STYLE_FALLING: w.value = 40000000 - k * stride;
                STYLE_SAME:    w.value = base;
                default: begin
                    case ($urandom_range(0, 4))
                        0:       w.value = 32'sh8000_0000;
                        1:       w.value = 32'sh7FFF_FFFF;
                        2:       w.value = 32'sd0;
                        3:       w.value = -32'sd1;
                        default: w.value = $urandom;
                    endcase
                end
            endcase
            w.is_last_in = (k == n - 1);
            offer_word(w, 1'b0, '0);
            if (!bursty && $urandom_range(0, 2) == 0) begin
                idle_sender(pick_gap());
            end
        end
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[r]) begin
            offer_word(directed[r].word, directed[r].typed, directed[r].result);
            if ($urandom_range(0, 1) == 0) begin
                idle_sender($urandom_range(1, 3));
            end
        end

        // full store, overflow with the last two words dropped, worst-case ordering
        send_set(CAPACITY, STYLE_RANDOM, 1'b0);
        send_set(CAPACITY + 2, STYLE_NARROW, 1'b1);
        send_set(CAPACITY, STYLE_RISING, 1'b1);
        drain_results();

        // stall the sink while sets keep coming, so the input backs up
        hold_off_req = 1'b1;
        wait (hold_on);
        repeat (3) send_set(12, STYLE_RANDOM, 1'b1);
        drain_results();

        while (words_taken < ITEMS) begin
            send_set(pick_size(), fill_style_t'($urandom_range(0, 5)),
                     $urandom_range(0, 3) == 0);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (!failed) begin
            $display("quicksort_three_way: match");
        end else begin
            $display("quicksort_three_way: mismatch");
        end
        $finish;
    end

    initial begin : result_sink
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                hold_on = 1'b1;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_off_req = 1'b0;
                hold_on      = 1'b0;
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(100, 300)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
            if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        out_item_t due;
        if (aresetn && m_valid && m_ready) begin
            if (sorted_due.size() == 0) begin
                $error("unexpected word: sorted_value %0d", m_data.sorted_value);
                failed = 1'b1;
            end else begin
                due = sorted_due.pop_front();
                if (m_data.sorted_value !== due.sorted_value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           due.sorted_value, m_data.sorted_value);
                    failed = 1'b1;
                end
                if (m_data.is_last_out !== due.is_last_out) begin
                    $error("is_last_out: expected %0b, got %0b",
                           due.is_last_out, m_data.is_last_out);
                    failed = 1'b1;
                end
                if (m_data.overflow !== due.overflow) begin
                    $error("overflow: expected %0b, got %0b",
                           due.overflow, m_data.overflow);
                    failed = 1'b1;
                end
            end
        end
    end

    // count cycles in which no word moves on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("quicksort_three_way: mismatch");
            $finish;
        end
    end

endmodule
